[sv/pfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// shared types, constants and colour packing for the palette frame decoder
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int unsigned PAL_ADDR_W = 8;
    localparam int unsigned PAL_DATA_W = 16;
    localparam int unsigned DIM_W      = 10;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

    // colour component of a header byte
    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2
    } t_comp;

    localparam logic [PAL_ADDR_W-1:0] LAST_ENTRY = '1;

    // per-transfer control from the sequencer to the palette and result path
    typedef struct packed {
        logic                  wr_en;
        logic [PAL_ADDR_W-1:0] wr_addr;
        logic [PAL_DATA_W-1:0] wr_data;
        logic                  rd_en;
        logic [PAL_ADDR_W-1:0] rd_addr;
        logic                  end_of_row;
        logic                  end_of_frame;
    } t_pfd_ctl;

    function automatic logic [PAL_DATA_W-1:0] pack_rgb565(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        logic [7:0] rm;
        logic [7:0] gm;
        rm = r & RED_MASK;
        gm = g & GREEN_MASK;
        return {rm[7:3], gm[7:2], b[7:3]};
    endfunction

endpackage
`default_nettype wire

[sv/pfd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_ctrl
// header/pixel sequencer: gathers colour triples, counts columns and rows
// ----------------------------------------------------------------------------
module pfd_ctrl
    import pfd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [DIM_W-1:0] i_row_width,
    input  wire logic [DIM_W-1:0] i_row_count,
    output t_pfd_ctl              o_ctl
);

    logic                  r_pixel_phase, n_pixel_phase;
    t_comp                 r_comp, n_comp;
    logic [PAL_ADDR_W-1:0] r_entry, n_entry;
    logic [7:0]            r_red, n_red;
    logic [7:0]            r_green, n_green;
    logic [DIM_W-1:0]      r_col, n_col;
    logic [DIM_W-1:0]      r_line, n_line;

    logic row_end;
    logic frame_end;

    // a limit of zero behaves as one
    assign row_end   = ({1'b0, r_col} + 11'd1) >= {1'b0, i_row_width};
    assign frame_end = row_end && (({1'b0, r_line} + 11'd1) >= {1'b0, i_row_count});

    always_comb begin
        o_ctl.wr_en        = i_accept && !r_pixel_phase && (r_comp == COMP_BLUE);
        o_ctl.wr_addr      = r_entry;
        o_ctl.wr_data      = pack_rgb565(r_red, r_green, i_data_byte);
        o_ctl.rd_en        = i_accept && r_pixel_phase;
        o_ctl.rd_addr      = i_data_byte;
        o_ctl.end_of_row   = row_end;
        o_ctl.end_of_frame = frame_end;
    end

    always_comb begin
        n_pixel_phase = r_pixel_phase;
        n_comp        = r_comp;
        n_entry       = r_entry;
        n_red         = r_red;
        n_green       = r_green;
        n_col         = r_col;
        n_line        = r_line;
        if (i_accept && !r_pixel_phase) begin
            unique case (r_comp)
                COMP_RED: begin
                    n_red  = i_data_byte;
                    n_comp = COMP_GREEN;
                end
                COMP_GREEN: begin
                    n_green = i_data_byte;
                    n_comp  = COMP_BLUE;
                end
                COMP_BLUE: begin
                    n_comp  = COMP_RED;
                    n_entry = r_entry + 1'b1;
                    // last triple of the header opens the pixel phase
                    if (r_entry == LAST_ENTRY) begin
                        n_pixel_phase = 1'b1;
                        n_col         = '0;
                        n_line        = '0;
                    end
                end
                default: begin
                    n_comp = COMP_RED;
                end
            endcase
        end else if (i_accept) begin
            if (frame_end) begin
                n_pixel_phase = 1'b0;
                n_comp        = COMP_RED;
                n_entry       = '0;
                n_col         = '0;
                n_line        = '0;
            end else if (row_end) begin
                n_col  = '0;
                n_line = r_line + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_phase <= 1'b0;
            r_comp        <= COMP_RED;
            r_entry       <= '0;
            r_red         <= '0;
            r_green       <= '0;
            r_col         <= '0;
            r_line        <= '0;
        end else begin
            r_pixel_phase <= n_pixel_phase;
            r_comp        <= n_comp;
            r_entry       <= n_entry;
            r_red         <= n_red;
            r_green       <= n_green;
            r_col         <= n_col;
            r_line        <= n_line;
        end
    end

endmodule
`default_nettype wire

[sv/pfd_palram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_palram
// 256 x 16 palette store, one write and one registered read port
// ----------------------------------------------------------------------------
module pfd_palram
    import pfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [PAL_ADDR_W-1:0] i_wr_addr,
    input  wire logic [PAL_DATA_W-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [PAL_ADDR_W-1:0] i_rd_addr,
    output logic      [PAL_DATA_W-1:0] o_rd_data
);

    logic [PAL_DATA_W-1:0] r_mem [2**PAL_ADDR_W];
    logic [PAL_DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[sv/palette_frame_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_frame_decoder
// decodes palette-indexed frames from a byte stream into rgb565 pixels
// ----------------------------------------------------------------------------
//  channel   | direction | tdata              | tlast       | tuser
//  s_axis    | in        | [7:0] data_byte    | -           | -
//  m_axis    | out       | [15:0] pixel_rgb565| end_of_row  | end_of_frame
//  cfg       | in        | [9:0] wdata, index 0 row_width, 1 row_count
//
//  one byte per cycle in, one pixel per cycle out, while m_axis is ready; each
//  pixel passes the palette read register, then the output register, to m_axis
//  header bytes give no transfer on m_axis
//  a byte is taken while a result waits, as long as the read stage is free
//  synchronous active-low reset; the palette store is not cleared
// ----------------------------------------------------------------------------
module palette_frame_decoder
    import pfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input byte stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    // pixel stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [15:0]          m_axis_tdata,   // [15:0] pixel_rgb565
    output logic                      m_axis_tlast,   // end_of_row
    output logic                      m_axis_tuser,   // [0] end_of_frame
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_wdata
);

    logic [DIM_W-1:0] r_row_width;
    logic [DIM_W-1:0] r_row_count;

    t_pfd_ctl              ctl;
    logic                  in_accept;
    logic [PAL_DATA_W-1:0] rd_data;

    // read stage (palette data register lives in the ram)
    logic r_s1_valid, n_s1_valid;
    logic r_s1_last;
    logic r_s1_user;
    // output register
    logic                  r_s2_valid, n_s2_valid;
    logic [PAL_DATA_W-1:0] r_s2_data;
    logic                  r_s2_last;
    logic                  r_s2_user;

    logic s2_free;
    logic s1_free;
    logic s1_move;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 10'd280;
            r_row_count <= 10'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_WIDTH: r_row_width <= i_cfg_wdata;
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s2_free       = !r_s2_valid || m_axis_tready;
    assign s1_free       = !r_s1_valid || s2_free;
    assign s1_move       = r_s1_valid && s2_free;
    assign s_axis_tready = s1_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    pfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (s_axis_tdata),
        .i_row_width (r_row_width),
        .i_row_count (r_row_count),
        .o_ctl       (ctl)
    );

    pfd_palram u_palram (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.wr_en),
        .i_wr_addr (ctl.wr_addr),
        .i_wr_data (ctl.wr_data),
        .i_rd_en   (ctl.rd_en),
        .i_rd_addr (ctl.rd_addr),
        .o_rd_data (rd_data)
    );

    // read stage fills on a pixel transfer, drains into the output register
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_free) begin
            n_s1_valid = ctl.rd_en;
        end
        n_s2_valid = r_s2_valid;
        if (s2_free) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.rd_en) begin
            r_s1_last <= ctl.end_of_row;
            r_s1_user <= ctl.end_of_frame;
        end
        if (s1_move) begin
            r_s2_data <= rd_data;
            r_s2_last <= r_s1_last;
            r_s2_user <= r_s1_user;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = r_s2_data;
    assign m_axis_tlast  = r_s2_last;
    assign m_axis_tuser  = r_s2_user;

`ifndef SYNTHESIS
    // frame end only ever comes with a row end
    a_eof_has_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of frame without end of row");

    // both stages full and stalled: no byte may be taken
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s2_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("byte taken with pipeline full");

    // a pixel transfer always lands in the read stage
    a_pixel_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rd_en |=> r_s1_valid)
        else $error("pixel lost after transfer");

    // header bytes never write and read the palette in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.wr_en && ctl.rd_en))
        else $error("palette written and read together");

    // nothing leaves straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
